### sv/dual_exposure_timer_keypad_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dual exposure timer
// Concurrent checks on the timer's internal control, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef DUAL_EXPOSURE_TIMER_KEYPAD_TOP_ASSERT_SVH
`define DUAL_EXPOSURE_TIMER_KEYPAD_TOP_ASSERT_SVH

// Same-cycle implication
`define DETK_ASSERT_NOW(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) else $error(msg);

// Next-cycle implication
`define DETK_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);

`endif

### sv/detk_pkg.sv
// ----------------------------------------------------------------------------
// Dual exposure timer package
// Types, codes and constants shared by the timer modules.
// ----------------------------------------------------------------------------
package detk_pkg;

   localparam int CountWidth = 14;
   localparam int StepWidth  = 10;
   localparam int KeyWidth   = 5;
   localparam int PortWidth  = 6;

   localparam logic ACTION_TICK = 1'b0;
   localparam logic ACTION_POLL = 1'b1;

   localparam logic [PortWidth-1:0] MOTOR_CLEAR_MASK = 6'h3C;
   localparam logic [PortWidth-1:0] MOTOR_FWD_BIT    = 6'h01;
   localparam logic [PortWidth-1:0] MOTOR_REV_BIT    = 6'h02;
   localparam logic [PortWidth-1:0] LIGHT_A_BIT      = 6'h04;
   localparam logic [PortWidth-1:0] LIGHT_B_BIT      = 6'h08;
   localparam logic [PortWidth-1:0] ENLARGER_BIT     = 6'h10;
   localparam logic [PortWidth-1:0] ROOM_BIT         = 6'h20;

   typedef enum logic [1:0] {
      MODE_IDLE      = 2'd0,
      MODE_PARALLEL  = 2'd1,
      MODE_B_THEN_A  = 2'd2
   } mode_type;

   typedef enum logic [KeyWidth-1:0] {
      KEY_NONE      = 5'd0,
      KEY_INC_A     = 5'd1,
      KEY_INC_B     = 5'd2,
      KEY_PRESET    = 5'd3,
      KEY_ENLARGER  = 5'd4,
      KEY_DEC_A     = 5'd5,
      KEY_DEC_B     = 5'd6,
      KEY_RUN_PAR   = 5'd7,
      KEY_ROOM      = 5'd8,
      KEY_LIGHT_A   = 5'd9,
      KEY_LIGHT_B   = 5'd10,
      KEY_RUN_SEQ   = 5'd11,
      KEY_MOTOR_REV = 5'd12,
      KEY_MOTOR_FWD = 5'd16
   } key_type;

   typedef enum logic [2:0] {
      REG_ACTIVE_HIGH    = 3'd0,
      REG_PRESET_A       = 3'd1,
      REG_PRESET_B       = 3'd2,
      REG_STEP_THRESHOLD = 3'd3,
      REG_COARSE_STEP    = 3'd4,
      REG_TIME_LIMIT     = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic                  active_high;
      logic [CountWidth-1:0] preset_a;
      logic [CountWidth-1:0] preset_b;
      logic [CountWidth-1:0] step_threshold;
      logic [StepWidth-1:0]  coarse_step;
      logic [CountWidth-1:0] time_limit;
   } cfg_type;

   typedef struct packed {
      logic       action;
      logic [3:0] col_sample_0;
      logic [3:0] col_sample_1;
      logic [3:0] col_sample_2;
      logic [3:0] col_sample_3;
   } item_type;

   typedef struct packed {
      logic [PortWidth-1:0]  drive_bits;
      logic [CountWidth-1:0] remaining_a;
      logic [CountWidth-1:0] remaining_b;
      mode_type              mode;
   } state_type;

   function automatic logic [PortWidth-1:0] set_lights(
      input logic [PortWidth-1:0] drive,
      input logic                 a_on,
      input logic                 b_on,
      input logic                 active_high
   );
      logic [PortWidth-1:0] on_bits;
      logic [PortWidth-1:0] level;
      on_bits = (a_on ? LIGHT_A_BIT : '0) | (b_on ? LIGHT_B_BIT : '0);
      level   = active_high ? on_bits : (~on_bits & (LIGHT_A_BIT | LIGHT_B_BIT));
      return (drive & ~(LIGHT_A_BIT | LIGHT_B_BIT)) | level;
   endfunction

endpackage

### sv/detk_req_if.sv
// ----------------------------------------------------------------------------
// Timer request channel
// Valid/ready channel carrying one tick or keypad poll transaction.
// ----------------------------------------------------------------------------
interface detk_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [3:0] col_sample_0;
   logic [3:0] col_sample_1;
   logic [3:0] col_sample_2;
   logic [3:0] col_sample_3;

   modport source (
      output valid, action, col_sample_0, col_sample_1, col_sample_2, col_sample_3,
      input  ready
   );
   modport sink (
      input  valid, action, col_sample_0, col_sample_1, col_sample_2, col_sample_3,
      output ready
   );
endinterface

### sv/detk_rsp_if.sv
// ----------------------------------------------------------------------------
// Timer response channel
// Valid/ready channel carrying the timer state after each transaction.
// ----------------------------------------------------------------------------
interface detk_rsp_if;
   logic        valid;
   logic        ready;
   logic [5:0]  port_bits;
   logic [13:0] count_a;
   logic [13:0] count_b;
   logic [1:0]  run_mode;
   logic [4:0]  key_code;

   modport source (
      output valid, port_bits, count_a, count_b, run_mode, key_code,
      input  ready
   );
   modport sink (
      input  valid, port_bits, count_a, count_b, run_mode, key_code,
      output ready
   );
endinterface

### sv/dual_exposure_timer_keypad_top.sv
// ----------------------------------------------------------------------------
// Dual exposure timer with keypad
// Takes one tick or keypad poll per cycle and returns one response carrying
// the light/motor drive bits, both remaining counts, the run mode and the
// decoded key. A transaction is registered on acceptance, passes through one
// stage of step logic and lands in the state/response register, and a new
// request is taken every cycle while the response side keeps up. The timer
// state register is the only loop through the step logic. Settings are to be
// written over the APB port only while no transaction is in flight; the block
// does not enforce this itself.
// ----------------------------------------------------------------------------
module dual_exposure_timer_keypad_top (
   input  logic        clock,
   input  logic        reset,
   detk_req_if.sink    req,
   detk_rsp_if.source  rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   `include "dual_exposure_timer_keypad_top_assert.svh"

   detk_pkg::cfg_type   cfg_ff;
   detk_pkg::cfg_type   cfg_in;
   detk_pkg::item_type  item_ff;
   detk_pkg::item_type  item_in;
   logic                item_valid_ff;
   logic                item_valid_in;
   detk_pkg::state_type state_ff;
   detk_pkg::state_type state_in;
   detk_pkg::state_type state_next;
   logic [4:0]          key_ff;
   logic [4:0]          key_in;
   logic [4:0]          key_next;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                advance;
   logic                req_take;
   logic                csr_write;
   detk_pkg::reg_index_type csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = detk_pkg::reg_index_type'(csr_paddr[4:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            detk_pkg::REG_ACTIVE_HIGH:    cfg_in.active_high    = csr_pwdata[0];
            detk_pkg::REG_PRESET_A:       cfg_in.preset_a       = csr_pwdata[13:0];
            detk_pkg::REG_PRESET_B:       cfg_in.preset_b       = csr_pwdata[13:0];
            detk_pkg::REG_STEP_THRESHOLD: cfg_in.step_threshold = csr_pwdata[13:0];
            detk_pkg::REG_COARSE_STEP:    cfg_in.coarse_step    = csr_pwdata[9:0];
            detk_pkg::REG_TIME_LIMIT:     cfg_in.time_limit     = csr_pwdata[13:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         detk_pkg::REG_ACTIVE_HIGH:    csr_prdata = 32'(cfg_ff.active_high);
         detk_pkg::REG_PRESET_A:       csr_prdata = 32'(cfg_ff.preset_a);
         detk_pkg::REG_PRESET_B:       csr_prdata = 32'(cfg_ff.preset_b);
         detk_pkg::REG_STEP_THRESHOLD: csr_prdata = 32'(cfg_ff.step_threshold);
         detk_pkg::REG_COARSE_STEP:    csr_prdata = 32'(cfg_ff.coarse_step);
         detk_pkg::REG_TIME_LIMIT:     csr_prdata = 32'(cfg_ff.time_limit);
         default:                      csr_prdata = '0;
      endcase
   end

   // advance the held transaction once the response register is free
   assign advance   = item_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !item_valid_ff || advance;
   assign req_take  = req.valid && req.ready;

   assign item_in.action       = req.action;
   assign item_in.col_sample_0 = req.col_sample_0;
   assign item_in.col_sample_1 = req.col_sample_1;
   assign item_in.col_sample_2 = req.col_sample_2;
   assign item_in.col_sample_3 = req.col_sample_3;

   assign item_valid_in = req_take || (item_valid_ff && !advance);
   assign rsp_valid_in  = advance || (rsp_valid_ff && !rsp.ready);
   assign state_in      = advance ? state_next : state_ff;
   assign key_in        = advance ? key_next : key_ff;

   detk_step u_step (
      .cfg        (cfg_ff),
      .item       (item_ff),
      .state      (state_ff),
      .state_next (state_next),
      .key_code   (key_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_high    <= 1'b1;
         cfg_ff.preset_a       <= 14'd25;
         cfg_ff.preset_b       <= 14'd30;
         cfg_ff.step_threshold <= 14'd50;
         cfg_ff.coarse_step    <= 10'd10;
         cfg_ff.time_limit     <= 14'd9999;
         item_valid_ff         <= 1'b0;
         rsp_valid_ff          <= 1'b0;
         state_ff              <= '0;
      end else begin
         cfg_ff        <= cfg_in;
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         state_ff      <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= item_in;
      end
      key_ff <= key_in;
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.port_bits = state_ff.drive_bits;
   assign rsp.count_a   = state_ff.remaining_a;
   assign rsp.count_b   = state_ff.remaining_b;
   assign rsp.run_mode  = state_ff.mode;
   assign rsp.key_code  = key_ff;

   `DETK_ASSERT_NEXT(a_idle_tick_holds, clock, reset,
      advance && item_ff.action == detk_pkg::ACTION_TICK
      && state_ff.mode == detk_pkg::MODE_IDLE,
      $stable(state_ff), "tick while idle changed the timer state")
   `DETK_ASSERT_NEXT(a_run_ends_idle, clock, reset,
      advance && item_ff.action == detk_pkg::ACTION_TICK
      && state_ff.mode != detk_pkg::MODE_IDLE,
      state_ff.mode == detk_pkg::MODE_IDLE || state_ff.remaining_a != '0
      || state_ff.remaining_b != '0, "run left active with both counts at zero")
   `DETK_ASSERT_NEXT(a_tick_no_key, clock, reset,
      advance && item_ff.action == detk_pkg::ACTION_TICK,
      rsp.valid && rsp.key_code == detk_pkg::KEY_NONE, "tick response carries a key")
   `DETK_ASSERT_NOW(a_state_held_while_stalled, clock, reset,
      rsp_valid_ff && !rsp.ready, !advance, "state advanced under a stalled response")

endmodule

### sv/detk_step.sv
// ----------------------------------------------------------------------------
// Timer step logic
// Decodes the keypad sample and computes the next timer state for one
// tick or poll transaction.
// ----------------------------------------------------------------------------
module detk_step (
   input  detk_pkg::cfg_type   cfg,
   input  detk_pkg::item_type  item,
   input  detk_pkg::state_type state,
   output detk_pkg::state_type state_next,
   output logic [4:0]          key_code
);

   logic [3:0]                        nibble [4];
   logic [detk_pkg::KeyWidth-1:0]     key;
   logic [detk_pkg::CountWidth:0]     bump_a;
   logic [detk_pkg::CountWidth:0]     bump_b;
   logic [detk_pkg::CountWidth-1:0]   inc_a;
   logic [detk_pkg::CountWidth-1:0]   inc_b;
   logic [detk_pkg::CountWidth-1:0]   load_a;
   logic [detk_pkg::CountWidth-1:0]   load_b;
   logic                              a_live;
   logic                              b_live;

   assign nibble[0] = item.col_sample_0;
   assign nibble[1] = item.col_sample_1;
   assign nibble[2] = item.col_sample_2;
   assign nibble[3] = item.col_sample_3;

   // last column with a single row bit wins
   always_comb begin
      key = detk_pkg::KEY_NONE;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            if (nibble[c] == (4'b0001 << r)) begin
               key = detk_pkg::KeyWidth'(c * 4 + r + 1);
            end
         end
      end
   end

   assign bump_a = (state.remaining_a >= cfg.step_threshold)
                 ? {1'b0, state.remaining_a} + (detk_pkg::CountWidth + 1)'(cfg.coarse_step)
                 : {1'b0, state.remaining_a} + (detk_pkg::CountWidth + 1)'(1);
   assign bump_b = (state.remaining_b >= cfg.step_threshold)
                 ? {1'b0, state.remaining_b} + (detk_pkg::CountWidth + 1)'(cfg.coarse_step)
                 : {1'b0, state.remaining_b} + (detk_pkg::CountWidth + 1)'(1);
   assign inc_a  = (bump_a > {1'b0, cfg.time_limit}) ? cfg.time_limit
                                                     : bump_a[detk_pkg::CountWidth-1:0];
   assign inc_b  = (bump_b > {1'b0, cfg.time_limit}) ? cfg.time_limit
                                                     : bump_b[detk_pkg::CountWidth-1:0];
   assign load_a = (cfg.preset_a > cfg.time_limit) ? cfg.time_limit : cfg.preset_a;
   assign load_b = (cfg.preset_b > cfg.time_limit) ? cfg.time_limit : cfg.preset_b;

   assign a_live = (state.remaining_a != '0);
   assign b_live = (state.remaining_b != '0);

   always_comb begin
      state_next = state;
      key_code   = detk_pkg::KEY_NONE;
      if (item.action == detk_pkg::ACTION_TICK) begin
         case (state.mode)
            detk_pkg::MODE_PARALLEL: begin
               if (a_live || b_live) begin
                  state_next.drive_bits = detk_pkg::set_lights(state.drive_bits, a_live,
                                                               b_live, cfg.active_high);
               end
               if (a_live) begin
                  state_next.remaining_a = state.remaining_a - 1'b1;
               end
               if (b_live) begin
                  state_next.remaining_b = state.remaining_b - 1'b1;
               end
            end
            detk_pkg::MODE_B_THEN_A: begin
               if (b_live) begin
                  state_next.drive_bits  = detk_pkg::set_lights(state.drive_bits, 1'b0,
                                                                1'b1, cfg.active_high);
                  state_next.remaining_b = state.remaining_b - 1'b1;
               end else if (a_live) begin
                  state_next.drive_bits  = detk_pkg::set_lights(state.drive_bits, 1'b1,
                                                                1'b0, cfg.active_high);
                  state_next.remaining_a = state.remaining_a - 1'b1;
               end
            end
            default: begin
            end
         endcase
         if ((state.mode == detk_pkg::MODE_PARALLEL || state.mode == detk_pkg::MODE_B_THEN_A)
             && state_next.remaining_a == '0 && state_next.remaining_b == '0) begin
            state_next.drive_bits = detk_pkg::set_lights(state_next.drive_bits, 1'b0, 1'b0,
                                                         cfg.active_high);
            state_next.mode       = detk_pkg::MODE_IDLE;
         end
      end else begin
         key_code = key;
         case (key)
            detk_pkg::KEY_NONE:
               state_next.drive_bits = state.drive_bits & detk_pkg::MOTOR_CLEAR_MASK;
            detk_pkg::KEY_INC_A:    state_next.remaining_a = inc_a;
            detk_pkg::KEY_INC_B:    state_next.remaining_b = inc_b;
            detk_pkg::KEY_PRESET: begin
               state_next.remaining_a = load_a;
               state_next.remaining_b = load_b;
            end
            detk_pkg::KEY_ENLARGER:
               state_next.drive_bits = state.drive_bits ^ detk_pkg::ENLARGER_BIT;
            detk_pkg::KEY_DEC_A: begin
               if (a_live) begin
                  state_next.remaining_a = state.remaining_a - 1'b1;
               end
            end
            detk_pkg::KEY_DEC_B: begin
               if (b_live) begin
                  state_next.remaining_b = state.remaining_b - 1'b1;
               end
            end
            detk_pkg::KEY_RUN_PAR:  state_next.mode = detk_pkg::MODE_PARALLEL;
            detk_pkg::KEY_ROOM:
               state_next.drive_bits = state.drive_bits ^ detk_pkg::ROOM_BIT;
            detk_pkg::KEY_LIGHT_A:
               state_next.drive_bits = state.drive_bits ^ detk_pkg::LIGHT_A_BIT;
            detk_pkg::KEY_LIGHT_B:
               state_next.drive_bits = state.drive_bits ^ detk_pkg::LIGHT_B_BIT;
            detk_pkg::KEY_RUN_SEQ:  state_next.mode = detk_pkg::MODE_B_THEN_A;
            detk_pkg::KEY_MOTOR_REV:
               state_next.drive_bits = (state.drive_bits & ~detk_pkg::MOTOR_FWD_BIT)
                                     | detk_pkg::MOTOR_REV_BIT;
            detk_pkg::KEY_MOTOR_FWD:
               state_next.drive_bits = (state.drive_bits & ~detk_pkg::MOTOR_REV_BIT)
                                     | detk_pkg::MOTOR_FWD_BIT;
            default: begin
            end
         endcase
      end
   end

endmodule
